>>> design/tmch_pkg.sv
// Shared types, constants and helper functions of the mismatch code histogram.
`timescale 1ns / 1ps
`default_nettype none

package tmch_pkg;

    // Defaults of the top-level parameters
    localparam int NUM_PROBES_DEF = 4;
    localparam int COUNT_BITS_DEF = 16;

    // Fixed field widths
    localparam int MIS_FIELDS   = 4;
    localparam int MIS_W        = 12;
    localparam int MEMB_W       = 2;
    localparam int CODE_W       = 7;
    localparam int REPORT_W     = 16;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 12;
    localparam int QUEUE_DEPTH  = 2;
    localparam int QUEUE_PTR_W  = $clog2(QUEUE_DEPTH);

    // Operation codes
    localparam logic OP_COUNT = 1'b0;
    localparam logic OP_READ  = 1'b1;

    // Membership codes; the remaining codes mean unknown
    localparam logic [MEMB_W-1:0] MEMB_IN  = 2'd0;
    localparam logic [MEMB_W-1:0] MEMB_OUT = 2'd1;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ALLOWED_0 = 3'd0,
        REG_ALLOWED_1 = 3'd1,
        REG_ALLOWED_2 = 3'd2,
        REG_ALLOWED_3 = 3'd3,
        REG_GREY_ZONE = 3'd4,
        REG_OUTSIDE   = 3'd5
    } cfg_reg_t;

    // One classified item on its way from front to back
    typedef struct packed {
        logic              op;
        logic              out_of_range;
        logic [MEMB_W-1:0] membership;
        logic [CODE_W-1:0] code;
    } item_t;

    // Probes that have a mismatch field
    function automatic int live_probes(input int num_probes);
        return (num_probes < MIS_FIELDS) ? num_probes : MIS_FIELDS;
    endfunction

    // Three to the given power
    function automatic int pow3(input int n);
        int acc;
        acc = 1;
        for (int k = 0; k < n; k++) begin
            acc = acc * 3;
        end
        return acc;
    endfunction

endpackage

`default_nettype wire

>>> design/ternary_mismatch_code_histogram.sv
// An accepted item passes the queue, the fetch registers and the result registers.
// The back end takes a new item only after the fetch/execute read-modify-write of a bin.
// A two-entry queue takes up to two items ahead; busy is high only while it is full.
// Reset (rst_n low, asynchronous) clears state, queue pointers and all bin valid bits.
// The receiver cannot stall; each result is shown for exactly one cycle with done.
`timescale 1ns / 1ps
`default_nettype none

module ternary_mismatch_code_histogram
    import tmch_pkg::*;
#(
    parameter int NUM_PROBES = NUM_PROBES_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic                  op,
    input  wire logic [MIS_W-1:0]      mis_0,
    input  wire logic [MIS_W-1:0]      mis_1,
    input  wire logic [MIS_W-1:0]      mis_2,
    input  wire logic [MIS_W-1:0]      mis_3,
    input  wire logic [MEMB_W-1:0]     membership,
    input  wire logic [CODE_W-1:0]     bin_sel,
    output logic                       done,
    output logic [CODE_W-1:0]          code,
    output logic [REPORT_W-1:0]        in_count,
    output logic [REPORT_W-1:0]        out_count
);

    item_t front_item;
    item_t head;
    logic  push;
    logic  pop;
    logic  full;
    logic  empty;

    assign cfg_ready = 1'b1;
    assign busy      = full;
    assign push      = start && !full;

    // Classify
    tmch_front #(
        .NUM_PROBES (NUM_PROBES)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .op         (op),
        .mis_0      (mis_0),
        .mis_1      (mis_1),
        .mis_2      (mis_2),
        .mis_3      (mis_3),
        .membership (membership),
        .bin_sel    (bin_sel),
        .item       (front_item)
    );

    // Decouple
    tmch_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (front_item),
        .pop       (pop),
        .head      (head),
        .full      (full),
        .empty     (empty)
    );

    // Update histograms
    tmch_back #(
        .NUM_PROBES (NUM_PROBES),
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .empty     (empty),
        .pop       (pop),
        .done      (done),
        .code      (code),
        .in_count  (in_count),
        .out_count (out_count)
    );

endmodule

`default_nettype wire

>>> design/tmch_front.sv
// Front end: configuration registers, item intake and probe classification.
`timescale 1ns / 1ps
`default_nettype none

module tmch_front
    import tmch_pkg::*;
#(
    parameter int NUM_PROBES = NUM_PROBES_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_valid,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  op,
    input  wire logic [MIS_W-1:0]      mis_0,
    input  wire logic [MIS_W-1:0]      mis_1,
    input  wire logic [MIS_W-1:0]      mis_2,
    input  wire logic [MIS_W-1:0]      mis_3,
    input  wire logic [MEMB_W-1:0]     membership,
    input  wire logic [CODE_W-1:0]     bin_sel,
    output item_t                      item
);

    localparam int LIVE_PROBES = live_probes(NUM_PROBES);
    localparam int LIVE_BINS   = pow3(LIVE_PROBES);

    logic [MIS_W-1:0] allowed_reg [MIS_FIELDS];
    logic [MIS_W-1:0] grey_reg;
    logic [MIS_W-1:0] outside_reg;
    logic [MIS_W-1:0] mis_arr [MIS_FIELDS];
    logic [CODE_W-1:0] species_code;

    // Write configuration registers; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < MIS_FIELDS; j++)
            begin
                allowed_reg[j] <= '0;
            end
            grey_reg    <= '0;
            outside_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_ALLOWED_0: allowed_reg[0] <= cfg_data;
                REG_ALLOWED_1: allowed_reg[1] <= cfg_data;
                REG_ALLOWED_2: allowed_reg[2] <= cfg_data;
                REG_ALLOWED_3: allowed_reg[3] <= cfg_data;
                REG_GREY_ZONE: grey_reg       <= cfg_data;
                REG_OUTSIDE:   outside_reg    <= cfg_data;
                default:       ;
            endcase
        end
    end

    assign mis_arr[0] = mis_0;
    assign mis_arr[1] = mis_1;
    assign mis_arr[2] = mis_2;
    assign mis_arr[3] = mis_3;

    // Classify each live probe and weight its class by a power of three
    always_comb
    begin
        logic [MIS_W:0]   lim0;
        logic [MIS_W+1:0] lim1;
        logic [CODE_W-1:0] weight;
        species_code = '0;
        for (int j = 0; j < LIVE_PROBES; j++)
        begin
            lim0   = {1'b0, allowed_reg[j]} + {1'b0, grey_reg};
            lim1   = {1'b0, lim0} + {2'b00, outside_reg};
            weight = CODE_W'(pow3(j));
            if ({1'b0, mis_arr[j]} <= lim0)
            begin
                species_code = species_code;
            end
            else if ({2'b00, mis_arr[j]} <= lim1)
            begin
                species_code = species_code + weight;
            end
            else
            begin
                species_code = species_code + {weight[CODE_W-2:0], 1'b0};
            end
        end
    end

    // Build the queued item
    always_comb
    begin
        item.op           = op;
        item.membership   = membership;
        item.out_of_range = (op == OP_READ) && (bin_sel >= CODE_W'(LIVE_BINS));
        item.code         = (op == OP_READ) ? bin_sel : species_code;
    end

endmodule

`default_nettype wire

>>> design/tmch_queue.sv
// Short item queue between the front end and the histogram back end.
`timescale 1ns / 1ps
`default_nettype none

module tmch_queue
    import tmch_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  push,
    input  item_t      push_item,
    input  wire logic  pop,
    output item_t      head,
    output logic       full,
    output logic       empty
);

    item_t                  slot_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [QUEUE_PTR_W:0]   count_reg;

    assign full  = (count_reg == (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = slot_reg[rd_ptr_reg];

    // Store pushed items
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

>>> design/tmch_back.sv
// Back end: histogram memories, read-modify-write of one bin per counted item, read-and-clear for reads, result strobe.
`timescale 1ns / 1ps
`default_nettype none

module tmch_back
    import tmch_pkg::*;
#(
    parameter int NUM_PROBES = NUM_PROBES_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  item_t                     head,
    input  wire logic                 empty,
    output logic                      pop,
    output logic                      done,
    output logic [CODE_W-1:0]         code,
    output logic [REPORT_W-1:0]       in_count,
    output logic [REPORT_W-1:0]       out_count
);

    localparam int LIVE_BINS = pow3(live_probes(NUM_PROBES));
    localparam int ADDR_W    = $clog2(LIVE_BINS);

    typedef enum logic [1:0] {
        B_FETCH = 2'b01,
        B_EXEC  = 2'b10
    } back_state_t;

    back_state_t state_reg, state_next;

    logic [COUNT_BITS-1:0] in_mem  [LIVE_BINS];
    logic [COUNT_BITS-1:0] out_mem [LIVE_BINS];
    logic [LIVE_BINS-1:0]  valid_reg;

    item_t                 cur_reg;
    logic [ADDR_W-1:0]     rd_addr;
    logic [ADDR_W-1:0]     addr_reg;
    logic [COUNT_BITS-1:0] rd_in_reg;
    logic [COUNT_BITS-1:0] rd_out_reg;
    logic                  rd_valid_reg;

    logic [COUNT_BITS-1:0] cur_in;
    logic [COUNT_BITS-1:0] cur_out;
    logic [COUNT_BITS-1:0] new_in;
    logic [COUNT_BITS-1:0] new_out;
    logic                  exec;
    logic                  do_write;
    logic                  do_clear;

    logic                  done_reg;
    logic [CODE_W-1:0]     code_reg;
    logic [REPORT_W-1:0]   in_count_reg;
    logic [REPORT_W-1:0]   out_count_reg;

    // Saturating increment
    function automatic logic [COUNT_BITS-1:0] bump(input logic [COUNT_BITS-1:0] c);
        return (&c) ? c : c + 1'b1;
    endfunction

    // Clip a count to the result width
    function automatic logic [REPORT_W-1:0] report(input logic [COUNT_BITS-1:0] c);
        logic [31:0] w;
        w = 32'(c);
        return (|w[31:REPORT_W]) ? '1 : w[REPORT_W-1:0];
    endfunction

    assign pop     = (state_reg == B_FETCH) && !empty;
    assign exec    = (state_reg == B_EXEC);
    assign rd_addr = head.out_of_range ? '0 : head.code[ADDR_W-1:0];

    // Sequence fetch and execute
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_FETCH: if (!empty) state_next = B_EXEC;
            B_EXEC:  state_next = B_FETCH;
            default: state_next = B_FETCH;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_FETCH;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Read both histograms at the head item's bin
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_reg    <= head;
            addr_reg   <= rd_addr;
            rd_in_reg  <= in_mem[rd_addr];
            rd_out_reg <= out_mem[rd_addr];
        end
    end

    // Unwritten or cleared bins read as zero
    assign cur_in  = rd_valid_reg ? rd_in_reg  : '0;
    assign cur_out = rd_valid_reg ? rd_out_reg : '0;

    // Modify: count species by membership
    always_comb
    begin
        new_in  = cur_in;
        new_out = cur_out;
        if (cur_reg.membership == MEMB_IN)
        begin
            new_in = bump(cur_in);
        end
        else if (cur_reg.membership == MEMB_OUT)
        begin
            new_out = bump(cur_out);
        end
    end

    assign do_write = exec && (cur_reg.op == OP_COUNT);
    assign do_clear = exec && (cur_reg.op == OP_READ) && !cur_reg.out_of_range;

    // Write back updated counts
    always_ff @(posedge clk)
    begin
        if (do_write)
        begin
            in_mem[addr_reg]  <= new_in;
            out_mem[addr_reg] <= new_out;
        end
    end

    // Track which bins hold written counts
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
            if (do_write)
            begin
                valid_reg[addr_reg] <= 1'b1;
            end
            else if (do_clear)
            begin
                valid_reg[addr_reg] <= 1'b0;
            end
        end
    end

    // Register the result and its strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= exec;
        end
    end

    always_ff @(posedge clk)
    begin
        if (exec)
        begin
            code_reg <= cur_reg.code;
            if (cur_reg.op == OP_READ)
            begin
                in_count_reg  <= cur_reg.out_of_range ? '0 : report(cur_in);
                out_count_reg <= cur_reg.out_of_range ? '0 : report(cur_out);
            end
            else
            begin
                in_count_reg  <= report(new_in);
                out_count_reg <= report(new_out);
            end
        end
    end

    assign done      = done_reg;
    assign code      = code_reg;
    assign in_count  = in_count_reg;
    assign out_count = out_count_reg;

endmodule

`default_nettype wire

>>> design/tmch_checker.sv
// Port-level checker of the mismatch code histogram and its bind.
`timescale 1ns / 1ps
`default_nettype none

module tmch_port_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic start,
    input wire logic busy,
    input wire logic done
);

    // Result strobes never come back to back
    a_done_spacing: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe in two consecutive cycles");

    // Busy rises only after an item was taken
    a_busy_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start && !busy))
        else $error("busy rose without an accepted item");

    // The back end takes an item from a full queue at its next fetch
    a_busy_short: assert property (@(posedge clk) disable iff (!rst_n)
        (busy && $past(busy)) |=> !busy)
        else $error("busy held longer than two cycles");

endmodule

bind ternary_mismatch_code_histogram tmch_port_checker u_tmch_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done)
);

`default_nettype wire
